### src/spq_pkg.sv
// shared widths, codes and cell control type for the stable priority queue
`default_nettype none
package spq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ID_BITS_DEF  = 16;
  localparam int FUNC_W       = 2;
  localparam int AGE_W        = 7;
  localparam int PRIO_W       = 2;
  localparam int STAT_W       = 2;

  localparam logic [PRIO_W-1:0] REGULAR = 2'd1;

  typedef enum logic [FUNC_W-1:0] {
    FN_ENQ    = 2'd0,
    FN_DEQ    = 2'd1,
    FN_SEARCH = 2'd2,
    FN_REMOVE = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [AGE_W-1:0]  age;
    logic [PRIO_W-1:0] prio;
  } body_t;

  typedef struct packed {
    logic enq;
    logic deq;
    logic rem;
  } ctl_t;

endpackage
`default_nettype wire

### src/spq_cell.sv
// one queue slot: holds an entry and shifts toward front or back with its neighbors
`default_nettype none
module spq_cell #(
  parameter int ID_BITS = spq_pkg::ID_BITS_DEF
) (
  input  wire                  clk,
  input  spq_pkg::ctl_t        ctl,
  input  wire                  occ,
  input  wire  [ID_BITS-1:0]   new_id,
  input  spq_pkg::body_t       new_body,
  input  wire  [ID_BITS-1:0]   key,
  input  wire  [ID_BITS-1:0]   left_id,
  input  spq_pkg::body_t       left_body,
  input  wire  [ID_BITS-1:0]   right_id,
  input  spq_pkg::body_t       right_body,
  input  wire                  ge_in,
  input  wire                  found_in,
  input  wire  [ID_BITS-1:0]   acc_id_in,
  input  spq_pkg::body_t       acc_body_in,
  output logic [ID_BITS-1:0]   id_q,
  output spq_pkg::body_t       body_q,
  output logic                 ge_out,
  output logic                 found_out,
  output logic [ID_BITS-1:0]   acc_id_out,
  output spq_pkg::body_t       acc_body_out
);
  import spq_pkg::*;

  logic [ID_BITS-1:0] id_r, id_nxt;
  body_t              body_r, body_nxt;
  logic               match, sel;

  assign ge_out    = occ && (body_r.prio >= new_body.prio);
  assign match     = occ && (id_r == key);
  assign found_out = found_in | match;
  assign sel       = match & ~found_in;

  assign acc_id_out   = acc_id_in | (sel ? id_r : '0);
  assign acc_body_out = acc_body_in | (sel ? body_r : '0);

  assign id_q   = id_r;
  assign body_q = body_r;

  always_comb begin
    id_nxt   = id_r;
    body_nxt = body_r;
    if (ctl.enq) begin
      if (!ge_in) begin
        id_nxt   = left_id;
        body_nxt = left_body;
      end else if (!ge_out) begin
        id_nxt   = new_id;
        body_nxt = new_body;
      end
    end else if (ctl.deq || (ctl.rem && found_out)) begin
      id_nxt   = right_id;
      body_nxt = right_body;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    body_r <= body_nxt;
  end

endmodule
`default_nettype wire

### src/stable_priority_queue.sv
// top level of the stable priority queue built as a chain of slot cells
//
// command interface: an item is taken at a rising edge with start high and
// busy low. busy is always low, so one item can be taken every cycle.
// in_func selects enqueue, dequeue, search by id or remove by id.
// every item gives exactly one result, shown on the out_ ports for one cycle
// with out_valid high, in the cycle after the item is taken. the receiver
// cannot stall, so results are never held back and never lost.
// throughput is one item per cycle: every slot cell compares its entry with
// the new item in parallel and shifts one place in the same cycle; the search
// for the first id match ripples once along the chain of cells.
// entries are kept sorted front to back, equal priorities in arrival order.
// reset empties the queue (count to zero) and clears out_valid; slot contents
// are not cleared, since only slots below the count are ever read.
// an enqueue into a full queue drops the item and reports status full.
`default_nettype none
module stable_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = spq_pkg::ID_BITS_DEF,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire  [spq_pkg::FUNC_W-1:0]   in_func,
  input  wire  [ID_BITS-1:0]           in_cust_id,
  input  wire  [spq_pkg::AGE_W-1:0]    in_cust_age,
  input  wire  [spq_pkg::PRIO_W-1:0]   in_prio,
  output logic                         out_valid,
  output logic [spq_pkg::STAT_W-1:0]   out_status,
  output logic [ID_BITS-1:0]           out_id,
  output logic [spq_pkg::AGE_W-1:0]    out_age,
  output logic [spq_pkg::PRIO_W-1:0]   out_prio,
  output logic [CNT_W-1:0]             out_occupancy,
  output logic                         out_is_empty
);
  import spq_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  body_t            body_r, body_nxt;

  func_t  func;
  ctl_t   ctl;
  body_t  new_body;
  logic   full, empty;

  logic [ID_BITS-1:0] cid   [CAPACITY];
  body_t              cbody [CAPACITY];
  logic [CAPACITY:0]  ge;
  logic [CAPACITY:0]  found;
  logic [ID_BITS-1:0] acc_id   [CAPACITY+1];
  body_t              acc_body [CAPACITY+1];

  assign busy     = 1'b0;
  assign func     = func_t'(in_func);
  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign new_body = '{age: in_cust_age, prio: in_prio};

  assign ctl.enq = start && (func == FN_ENQ) && !full;
  assign ctl.deq = start && (func == FN_DEQ) && !empty;
  assign ctl.rem = start && (func == FN_REMOVE);

  assign ge[0]       = 1'b1;
  assign found[0]    = 1'b0;
  assign acc_id[0]   = '0;
  assign acc_body[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ID_BITS-1:0] l_id, r_id;
    body_t              l_body, r_body;
    if (i == 0) begin : g_first
      assign l_id   = in_cust_id;
      assign l_body = new_body;
    end else begin : g_mid_l
      assign l_id   = cid[i-1];
      assign l_body = cbody[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_id   = cid[i];
      assign r_body = cbody[i];
    end else begin : g_mid_r
      assign r_id   = cid[i+1];
      assign r_body = cbody[i+1];
    end

    spq_cell #(.ID_BITS(ID_BITS)) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .occ          (CNT_W'(i) < count_r),
      .new_id       (in_cust_id),
      .new_body     (new_body),
      .key          (in_cust_id),
      .left_id      (l_id),
      .left_body    (l_body),
      .right_id     (r_id),
      .right_body   (r_body),
      .ge_in        (ge[i]),
      .found_in     (found[i]),
      .acc_id_in    (acc_id[i]),
      .acc_body_in  (acc_body[i]),
      .id_q         (cid[i]),
      .body_q       (cbody[i]),
      .ge_out       (ge[i+1]),
      .found_out    (found[i+1]),
      .acc_id_out   (acc_id[i+1]),
      .acc_body_out (acc_body[i+1])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    id_nxt     = '0;
    body_nxt   = '0;
    unique case (func)
      FN_ENQ: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      FN_DEQ: begin
        if (empty) begin
          status_nxt    = ST_MISS;
          body_nxt.prio = REGULAR;
        end else begin
          id_nxt    = cid[0];
          body_nxt  = cbody[0];
          count_nxt = count_r - 1'b1;
        end
      end
      FN_SEARCH, FN_REMOVE: begin
        if (found[CAPACITY]) begin
          id_nxt   = acc_id[CAPACITY];
          body_nxt = acc_body[CAPACITY];
          if (func == FN_REMOVE) begin
            count_nxt = count_r - 1'b1;
          end
        end else begin
          status_nxt = ST_MISS;
        end
      end
      default: begin
        status_nxt = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= start;
      if (start) begin
        count_r <= count_nxt;
      end
    end
    if (start) begin
      status_r <= status_nxt;
      id_r     <= id_nxt;
      body_r   <= body_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_id        = id_r;
  assign out_age       = body_r.age;
  assign out_prio      = body_r.prio;
  assign out_occupancy = count_r;
  assign out_is_empty  = (count_r == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above capacity");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    start && (func == FN_ENQ) && full |=> count_r == FULL_CNT && status_r == ST_FULL)
    else $error("full enqueue changed the queue");

  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> out_valid)
    else $error("item without result");

  a_miss_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_MISS |-> out_id == '0 && out_age == '0)
    else $error("miss result carries entry data");

endmodule
`default_nettype wire

### tb/stable_priority_queue_test.sv
// self-checking testbench for the stable priority queue: directed table, then random operations
`default_nettype none
module stable_priority_queue_test;
  import spq_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int ID_W        = ID_BITS_DEF;
  localparam int CNT_W       = $clog2(CAP + 1);
  localparam int RAND_ITEMS  = 800;
  localparam int CALM_ITEMS  = 100;
  localparam int MAX_REPORTS = 10;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [AGE_W-1:0]  age;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [AGE_W-1:0]  age;
    logic [PRIO_W-1:0] prio;
    logic [CNT_W-1:0]  occ;
    logic              empty;
  } outcome_t;

  typedef struct {
    func_t             op;
    logic [ID_W-1:0]   id;
    logic [AGE_W-1:0]  age;
    logic [PRIO_W-1:0] prio;
    int                reps;
    bit                fixed;
    outcome_t          want;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [FUNC_W-1:0] in_func;
  logic [ID_W-1:0]   in_cust_id;
  logic [AGE_W-1:0]  in_cust_age;
  logic [PRIO_W-1:0] in_prio;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [ID_W-1:0]   out_id;
  logic [AGE_W-1:0]  out_age;
  logic [PRIO_W-1:0] out_prio;
  logic [CNT_W-1:0]  out_occupancy;
  logic              out_is_empty;

  entry_t   queue_store [CAP];
  int       held;
  outcome_t pending_results [$];
  row_t     stim_table [$];
  bit       row_fixed;
  outcome_t row_want;
  int       fails;
  int       checked;
  int       cycles;
  int       full_drops;
  int       misses;
  int       op_seen [4];

  stable_priority_queue #(
    .CAPACITY(CAP),
    .ID_BITS (ID_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_cust_id   (in_cust_id),
    .in_cust_age  (in_cust_age),
    .in_prio      (in_prio),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_id       (out_id),
    .out_age      (out_age),
    .out_prio     (out_prio),
    .out_occupancy(out_occupancy),
    .out_is_empty (out_is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // queue behavior: sorted by priority, equal priorities in arrival order
  function automatic outcome_t apply_op(func_t op, logic [ID_W-1:0] key,
                                        logic [AGE_W-1:0] age, logic [PRIO_W-1:0] pr);
    outcome_t o;
    int       pos;
    int       i;
    bit       take;
    o = '0;
    o.status = ST_OK;
    take = 1'b0;
    pos = 0;
    case (op)
      FN_ENQ: begin
        if (held >= CAP) begin
          o.status = ST_FULL;
        end else begin
          while (pos < held && queue_store[pos].prio >= pr) pos++;
          for (i = held; i > pos; i--) queue_store[i] = queue_store[i-1];
          queue_store[pos].id = key;
          queue_store[pos].age = age;
          queue_store[pos].prio = pr;
          held++;
        end
      end
      FN_DEQ: begin
        if (held == 0) begin
          o.status = ST_MISS;
          o.prio = REGULAR;
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        while (pos < held && queue_store[pos].id != key) pos++;
        if (pos >= held) begin
          o.status = ST_MISS;
        end else begin
          o.id = queue_store[pos].id;
          o.age = queue_store[pos].age;
          o.prio = queue_store[pos].prio;
          if (op == FN_REMOVE) begin
            for (i = pos; i + 1 < held; i++) queue_store[i] = queue_store[i+1];
            held--;
          end
        end
      end
    endcase
    if (take) begin
      o.id = queue_store[0].id;
      o.age = queue_store[0].age;
      o.prio = queue_store[0].prio;
      for (i = 0; i + 1 < held; i++) queue_store[i] = queue_store[i+1];
      held--;
    end
    o.occ = CNT_W'(held);
    o.empty = (held == 0);
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n) begin
      if (out_valid !== 1'b0) begin
        if (pending_results.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("unexpected result: st=%0d id=%h age=%0d prio=%0d occ=%0d empty=%0d",
                     out_status, out_id, out_age, out_prio, out_occupancy, out_is_empty);
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (out_status !== want.status || out_id !== want.id || out_age !== want.age ||
              out_prio !== want.prio || out_occupancy !== want.occ ||
              out_is_empty !== want.empty) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display({"mismatch at cycle %0d: expected st=%0d id=%h age=%0d prio=%0d ",
                        "occ=%0d empty=%0d, got st=%0d id=%h age=%0d prio=%0d occ=%0d ",
                        "empty=%0d"},
                       cycles, want.status, want.id, want.age, want.prio, want.occ,
                       want.empty, out_status, out_id, out_age, out_prio, out_occupancy,
                       out_is_empty);
          end
        end
      end
      if (start && busy === 1'b0) begin
        want = apply_op(func_t'(in_func), in_cust_id, in_cust_age, in_prio);
        op_seen[in_func]++;
        if (want.status == ST_FULL) full_drops++;
        if (want.status == ST_MISS) misses++;
        pending_results.push_back(row_fixed ? row_want : want);
      end
    end
  end

  function automatic void add_row(func_t op, int id, int age, int pr, int reps, bit fixed,
                                  status_t st, int oid, int oage, int opr, int occ);
    row_t r;
    r.op = op;
    r.id = ID_W'(id);
    r.age = AGE_W'(age);
    r.prio = PRIO_W'(pr);
    r.reps = reps;
    r.fixed = fixed;
    r.want.status = st;
    r.want.id = ID_W'(oid);
    r.want.age = AGE_W'(oage);
    r.want.prio = PRIO_W'(opr);
    r.want.occ = CNT_W'(occ);
    r.want.empty = (occ == 0);
    stim_table.push_back(r);
  endfunction

  function automatic func_t choose_op(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: return r < 70 ? FN_ENQ : r < 80 ? FN_DEQ : r < 90 ? FN_SEARCH : FN_REMOVE;
      1: return r < 15 ? FN_ENQ : r < 70 ? FN_DEQ : r < 85 ? FN_SEARCH : FN_REMOVE;
      default: return r < 30 ? FN_ENQ : r < 55 ? FN_DEQ : r < 78 ? FN_SEARCH : FN_REMOVE;
    endcase
  endfunction

  // mostly keys that collide or hit a held entry, some fully random
  function automatic logic [ID_W-1:0] choose_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return ID_W'($urandom_range(0, 15));
    if (r < 6 || held == 0) return ID_W'($urandom);
    return queue_store[$urandom_range(0, held - 1)].id;
  endfunction

  task automatic put_item(input func_t op, input logic [ID_W-1:0] id,
                          input logic [AGE_W-1:0] age, input logic [PRIO_W-1:0] pr,
                          input bit fixed, input outcome_t want);
    @(negedge clk);
    start <= 1'b1;
    in_func <= op;
    in_cust_id <= id;
    in_cust_age <= age;
    in_prio <= pr;
    row_fixed <= fixed;
    row_want <= want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      in_func <= FUNC_W'($urandom);
      in_cust_id <= ID_W'($urandom);
      in_cust_age <= AGE_W'($urandom);
      in_prio <= PRIO_W'($urandom);
    end
  endtask

  task automatic wait_drained;
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    int    mode;
    int    phase_left;
    int    n;
    int    k;
    bit    idling;
    row_t  r;
    func_t op;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FN_ENQ;
    in_cust_id = '0;
    in_cust_age = '0;
    in_prio = '0;
    row_fixed = 1'b0;
    row_want = '0;
    held = 0;

    add_row(FN_DEQ,    0,       0,    0, 1, 1, ST_MISS, 0,       0,   REGULAR, 0);
    add_row(FN_SEARCH, 0,       0,    0, 1, 1, ST_MISS, 0,       0,   0,       0);
    add_row(FN_REMOVE, 'hFFFF,  127,  3, 1, 1, ST_MISS, 0,       0,   0,       0);
    add_row(FN_ENQ,    'hFFFF,  127,  0, 1, 1, ST_OK,   0,       0,   0,       1);
    add_row(FN_ENQ,    0,       0,    3, 1, 1, ST_OK,   0,       0,   0,       2);
    add_row(FN_SEARCH, 'hFFFF,  0,    0, 1, 1, ST_OK,   'hFFFF,  127, 0,       2);
    add_row(FN_SEARCH, 'h1234,  0,    0, 1, 1, ST_MISS, 0,       0,   0,       2);
    add_row(FN_ENQ,    7,       1,    1, 6, 0, ST_OK,   0,       0,   0,       0);
    add_row(FN_ENQ,    8,       20,   2, 4, 0, ST_OK,   0,       0,   0,       0);
    add_row(FN_ENQ,    7,       40,   1, 4, 0, ST_OK,   0,       0,   0,       0);
    add_row(FN_ENQ,    'h5555,  'h2A, 3, 1, 1, ST_FULL, 0,       0,   0,       16);
    add_row(FN_SEARCH, 7,       0,    0, 1, 0, ST_OK,   0,       0,   0,       0);
    add_row(FN_REMOVE, 7,       0,    0, 2, 0, ST_OK,   0,       0,   0,       0);
    add_row(FN_SEARCH, 8,       0,    0, 1, 0, ST_OK,   0,       0,   0,       0);
    add_row(FN_REMOVE, 'hFFFF,  0,    0, 1, 0, ST_OK,   0,       0,   0,       0);
    add_row(FN_ENQ,    'hAAAA,  'h55, 2, 1, 0, ST_OK,   0,       0,   0,       0);
    add_row(FN_DEQ,    0,       0,    0, 3, 0, ST_OK,   0,       0,   0,       0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      r = stim_table[i];
      for (k = 0; k < r.reps; k++) begin
        if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 10));
        put_item(r.op, r.id, AGE_W'(r.age + k), r.prio, r.fixed, r.want);
      end
    end
    wait_drained;

    mode = 2;
    phase_left = 0;
    idling = 1'b1;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (phase_left == 0) begin
        mode = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 60);
        idling = ($urandom_range(0, 2) != 0);
      end
      phase_left--;
      if (n == RAND_ITEMS / 2) wait_drained;
      if (idling && n < RAND_ITEMS - CALM_ITEMS && $urandom_range(0, 4) == 0)
        hold_off($urandom_range(1, 10));
      op = choose_op(mode);
      put_item(op, choose_key(), AGE_W'($urandom), PRIO_W'($urandom), 1'b0, '0);
    end

    wait_drained;
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) fails++;

    $display("ran %0d items: %0d enqueue, %0d dequeue, %0d search, %0d remove",
             op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("%0d results checked, %0d dropped as full, %0d empty or not found, %0d failures",
             checked, full_drops, misses, fails);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
src/spq_pkg.sv
src/spq_cell.sv
src/stable_priority_queue.sv
tb/stable_priority_queue_test.sv
